>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions on clk_i and rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk_i, masked while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check prop on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/lskv_pkg.sv
// ---------------------------------------------------------------------------
// lskv_pkg
// Shared constants, codes and control types of the key/value table.
// ---------------------------------------------------------------------------
`default_nettype none

package lskv_pkg;

  // Table geometry
  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  // Port field widths
  localparam int OPCODE_W    = 2;
  localparam int KEY_PORT_W  = 32;
  localparam int VAL_PORT_W  = 32;
  localparam int COUNT_W     = 5;
  localparam int STATUS_W    = 2;

  // Stored widths: only the low bits of a port word are kept
  localparam int KW     = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam int VW     = (VALUE_WIDTH < VAL_PORT_W) ? VALUE_WIDTH : VAL_PORT_W;
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_STRICT = 2'd1,
    OP_PUT    = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // capture the input word, restart the scan
    logic advance;   // step to the next slot
    logic mark_hit;  // current slot matches, fetch the last entry
    logic commit;    // apply the operation to the table
    logic load_out;  // move the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic match;
    logic at_last;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/lskv_dp.sv
// ---------------------------------------------------------------------------
// lskv_dp
// Datapath: key and value memories, scan index, count and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module lskv_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lskv_pkg::ctrl_cmd_t            cmd_i,
  output lskv_pkg::dp_sts_t                   sts_o,
  input  wire logic [lskv_pkg::OPCODE_W-1:0]  opcode_i,
  input  wire logic [lskv_pkg::KEY_PORT_W-1:0] key_i,
  input  wire logic [lskv_pkg::VAL_PORT_W-1:0] value_i,
  input  wire logic [lskv_pkg::VAL_PORT_W-1:0] default_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                found_o,
  output logic [lskv_pkg::VAL_PORT_W-1:0]     value_out_o,
  output logic [lskv_pkg::COUNT_W-1:0]        entry_count_o,
  output logic [lskv_pkg::STATUS_W-1:0]       status_o
);
  import lskv_pkg::*;

  logic [KW-1:0]         key_mem [ENTRIES];
  logic [VW-1:0]         val_mem [ENTRIES];

  opcode_e               op_q;
  logic [KW-1:0]         key_q;
  logic [VW-1:0]         val_q;
  logic [VAL_PORT_W-1:0] dflt_q;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      idx_q, slot_q, last_idx, rd_addr;
  logic                  hit_q;
  logic [VW-1:0]         hit_val_q;
  logic [KW-1:0]         key_rd_q;
  logic [VW-1:0]         val_rd_q;

  logic [VAL_PORT_W-1:0] res_val_q, res_val_d;
  status_e               res_stat_q, res_stat_d;

  logic                  key_we, val_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [KW-1:0]         key_wdata;
  logic [VW-1:0]         val_wdata;
  logic                  out_valid_q;

  assign last_idx = IDX_W'(cnt_q - CNT_W'(1));

  always_comb begin
    if (cmd_i.accept) begin
      rd_addr = '0;
    end else if (cmd_i.mark_hit) begin
      rd_addr = last_idx;
    end else begin
      rd_addr = idx_q + IDX_W'(1);
    end
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.match    = (key_rd_q == key_q);
  assign sts_o.at_last  = (idx_q == last_idx);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // Operation: table writes, count update and result
  always_comb begin
    key_we     = 1'b0;
    val_we     = 1'b0;
    wr_addr    = slot_q;
    key_wdata  = key_rd_q;
    val_wdata  = val_rd_q;
    cnt_d      = cnt_q;
    res_stat_d = STAT_OK;
    res_val_d  = hit_q ? VAL_PORT_W'(hit_val_q) : '0;
    case (op_q)
      OP_LOOKUP: begin
        if (!hit_q) res_val_d = dflt_q;
      end
      OP_STRICT: begin
        if (!hit_q) res_stat_d = STAT_MISSING;
      end
      OP_PUT: begin
        val_wdata = val_q;
        key_wdata = key_q;
        if (hit_q) begin
          val_we = cmd_i.commit;
        end else if (cnt_q == CNT_W'(ENTRIES)) begin
          res_stat_d = STAT_FULL;
        end else begin
          wr_addr = IDX_W'(cnt_q);
          key_we  = cmd_i.commit;
          val_we  = cmd_i.commit;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        // Move the last entry into the freed slot
        if (hit_q) begin
          key_we = cmd_i.commit;
          val_we = cmd_i.commit;
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        res_stat_d = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_addr] <= key_wdata;
    if (val_we) val_mem[wr_addr] <= val_wdata;
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= opcode_e'(opcode_i);
      key_q  <= key_i[KW-1:0];
      val_q  <= value_i[VW-1:0];
      dflt_q <= default_value_i;
      idx_q  <= '0;
      hit_q  <= 1'b0;
    end else if (cmd_i.advance) begin
      idx_q  <= idx_q + IDX_W'(1);
    end else if (cmd_i.mark_hit) begin
      hit_q     <= 1'b1;
      slot_q    <= idx_q;
      hit_val_q <= val_rd_q;
    end
    if (cmd_i.commit) begin
      res_val_q  <= res_val_d;
      res_stat_q <= res_stat_d;
    end
    if (cmd_i.load_out) begin
      found_o       <= hit_q;
      value_out_o   <= res_val_q;
      entry_count_o <= COUNT_W'(cnt_q);
      status_o      <= res_stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) cnt_q <= cnt_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/lskv_ctrl.sv
// ---------------------------------------------------------------------------
// lskv_ctrl
// Controller: sequences accept, scan, commit and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module lskv_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output lskv_pkg::ctrl_cmd_t      cmd_o,
  input  wire lskv_pkg::dp_sts_t   sts_i
);
  import lskv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_ready_q && in_valid_i;
        if (cmd_o.accept) state_d = sts_i.cnt_zero ? S_ACT : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.mark_hit = sts_i.match;
        cmd_o.advance  = !sts_i.match && !sts_i.at_last;
        if (sts_i.match || sts_i.at_last) state_d = S_ACT;
      end
      S_ACT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

`default_nettype wire

>>> rtl/linear_scan_key_value_table_core.sv
// ---------------------------------------------------------------------------
// linear_scan_key_value_table_core
// Small key/value table searched by a linear scan over packed slots.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake                | words
//   --------+-----------+--------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o  | opcode, key, value, default
//   out     | output    | out_valid_o / out_ready_i| found, value_out, count, status
//
// One word at a time. A word passes through an accept step, a scan of the
// slots (up to the entry count, at least one slot when the table is not
// empty), a commit step and a load of the result into the output register.
// The scan rate is set by the single registered read port of the key memory.
// Reset clears the count, so no clearing pass runs; slot contents stay as is.
// A stalled output holds the controller in its final state; the next input
// word is taken once that result has moved into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_scan_key_value_table_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [lskv_pkg::OPCODE_W-1:0]   opcode_i,
  input  wire logic [lskv_pkg::KEY_PORT_W-1:0] key_i,
  input  wire logic [lskv_pkg::VAL_PORT_W-1:0] value_i,
  input  wire logic [lskv_pkg::VAL_PORT_W-1:0] default_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 found_o,
  output logic [lskv_pkg::VAL_PORT_W-1:0]      value_out_o,
  output logic [lskv_pkg::COUNT_W-1:0]         entry_count_o,
  output logic [lskv_pkg::STATUS_W-1:0]        status_o
);
  import lskv_pkg::*;

  `include "assert_macros.svh"

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequence the operation
  lskv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Hold the table, scan it, and register the result word
  lskv_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .key_i           (key_i),
    .value_i         (value_i),
    .default_value_i (default_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .value_out_o     (value_out_o),
    .entry_count_o   (entry_count_o),
    .status_o        (status_o)
  );

  // One word in flight: ready drops right after an accept
  `ASSERT_CLK(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o, "second word taken")

  // Never overwrite a result still waiting at the output
  `ASSERT_CLK(a_no_overwrite, cmd.load_out |-> !(out_valid_o && !out_ready_i), "result lost")

  // A full-table put or a strict miss never reports a hit or a value
  `ASSERT_CLK(a_err_no_hit, (out_valid_o && (status_o == STAT_FULL || status_o == STAT_MISSING)) |-> (!found_o && value_out_o == '0), "error word carries data")

  // No operation is committed during reset
  `ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !cmd.commit, "commit during reset")

endmodule

`default_nettype wire
